// ===== hw/rtl/cbdq_pkg.sv =====
`default_nettype none

package cbdq_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 3;
	localparam int unsigned SLOT_W     = 6;
	localparam int unsigned CB_DEPTH   = 64;

	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE    = 2'd2;

	localparam logic [1:0] FMT_FP32 = 2'd0;
	localparam logic [1:0] FMT_FP16 = 2'd1;
	localparam logic [1:0] FMT_BF16 = 2'd2;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_ELEMENT = 1'b1;

	localparam logic [31:0] NAN32     = 32'h7FC0_0000;
	localparam logic [31:0] INF32     = 32'h7F80_0000;
	localparam logic [31:0] ONE32     = 32'h3F80_0000;
	localparam logic [31:0] NEGZERO32 = 32'h8000_0000;

	typedef enum logic [3:0] {
		STEP_IDLE,
		STEP_UNPACK,
		STEP_NORM,
		STEP_ALIGN,
		STEP_ADD,
		STEP_LZ,
		STEP_SHC,
		STEP_SHF,
		STEP_PACK
	} step_t;

	typedef enum logic {OP_FMA, OP_NARROW} fop_t;
	typedef enum logic [1:0] {OPA_ACT, OPA_SUM, OPA_RES} opa_t;
	typedef enum logic [1:0] {OPB_CB, OPB_SCALE, OPB_ONE} opb_t;
	typedef enum logic [1:0] {OPC_SUM, OPC_NEGZERO, OPC_BIAS} opc_t;

	typedef struct packed {
		logic  take;
		step_t step;
		fop_t  op;
		opa_t  a_sel;
		opb_t  b_sel;
		opc_t  c_sel;
		logic  sum_wr;
		logic  sum_clr;
		logic  r_wr;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic bias_en;
		logic out_full;
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cbdq_if.sv =====
`default_nettype none

interface cbdq_item_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [5:0]  table_slot;
	logic [31:0] value_bits;
	logic [15:0] packed_window;
	logic [2:0]  code_pos;
	logic        last_element;
	logic [31:0] row_scale;
	logic [31:0] bias_value;

	modport source (
		output valid, action, table_slot, value_bits, packed_window, code_pos,
			last_element, row_scale, bias_value,
		input  ready
	);
	modport sink (
		input  valid, action, table_slot, value_bits, packed_window, code_pos,
			last_element, row_scale, bias_value,
		output ready
	);
endinterface

interface cbdq_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;

	modport source (output valid, result_bits, input ready);
	modport sink (input valid, result_bits, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cbdq_fpu.sv =====
`default_nettype none

// fp32 fused multiply-add, and narrowing to the element format, one step per command
module cbdq_fpu (
	input  wire                  clk,
	input  wire cbdq_pkg::step_t step,
	input  wire cbdq_pkg::fop_t  op,
	input  wire [1:0]            fmt,
	input  wire [31:0]           a,
	input  wire [31:0]           b,
	input  wire [31:0]           c,
	output logic [31:0]          res
);

	localparam logic [1:0] CLS_ZERO = 2'd0;
	localparam logic [1:0] CLS_FIN  = 2'd1;
	localparam logic [1:0] CLS_INF  = 2'd2;
	localparam logic [1:0] CLS_NAN  = 2'd3;

	typedef struct packed {
		logic [1:0]          cls;
		logic                neg;
		logic [23:0]         m;
		logic signed [11:0]  e;
	} unp_t;

	function automatic unp_t unpack32(input logic [31:0] x);
		unp_t u;
		u.neg = x[31];
		u.m   = '0;
		u.e   = '0;
		if (x[30:23] == 8'hFF) begin
			u.cls = (x[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
		end else if (x[30:23] == 8'h00) begin
			if (x[22:0] == 23'd0) begin
				u.cls = CLS_ZERO;
			end else begin
				u.cls = CLS_FIN;
				u.m   = {1'b0, x[22:0]};
				u.e   = -12'sd149;
			end
		end else begin
			u.cls = CLS_FIN;
			u.m   = {1'b1, x[22:0]};
			u.e   = $signed({4'b0, x[30:23]}) - 12'sd150;
		end
		return u;
	endfunction

	function automatic logic [6:0] lzc64(input logic [63:0] v);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) n = 7'(63 - i);
		end
		return n;
	endfunction

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		n = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

	// special-value path
	logic               sp_q;
	logic [31:0]        spv_q;
	logic [1:0]         rfmt_q;
	// product and addend
	logic [47:0]        prod_q;
	logic signed [11:0] pe_q;
	logic               pn_q;
	logic [23:0]        mc_q;
	logic signed [11:0] ec_q;
	logic               nc_q;
	logic               czero_q;
	logic [5:0]         lzp_q;
	logic [4:0]         lzc_q;
	// aligned operands
	logic [63:0]        big_m_q, small_m_q;
	logic signed [11:0] big_e_q;
	logic               big_n_q, small_n_q;
	logic [11:0]        dexp_q;
	// unrounded sum
	logic [63:0]        sum_m_q;
	logic signed [11:0] sum_e_q;
	logic               sum_n_q;
	logic [6:0]         lzs_q;
	logic signed [11:0] shift_q;
	logic               zero_q;
	logic [24:0]        q_q;
	logic               g_q, st_q;
	logic [11:0]        bexp_q;
	logic [31:0]        res_q;

	// target format of the rounding steps
	logic [4:0]         fb;
	logic signed [11:0] lsbmin;
	logic [31:0]        infb;
	logic [31:0]        sbit;

	always_comb begin
		unique case (rfmt_q)
			cbdq_pkg::FMT_FP16: begin
				fb = 5'd10; lsbmin = -12'sd24; infb = 32'h7C00; sbit = 32'h8000;
			end
			cbdq_pkg::FMT_BF16: begin
				fb = 5'd7; lsbmin = -12'sd133; infb = 32'h7F80; sbit = 32'h8000;
			end
			default: begin
				fb = 5'd23; lsbmin = -12'sd149; infb = cbdq_pkg::INF32;
				sbit = cbdq_pkg::NEGZERO32;
			end
		endcase
	end

	unp_t               ua, ub, uc;
	logic               np;
	logic [6:0]         xs, ys;
	logic [63:0]        xm, ym;
	logic signed [11:0] xe, ye;
	logic               swap;
	logic [63:0]        yal, tsum;
	logic [5:0]         dsh;
	logic signed [11:0] pmsb, s1, s2;
	logic [127:0]       ext;
	logic [4:0]         nsh;
	logic [63:0]        lsh;
	logic [24:0]        qr;
	logic [39:0]        v;
	logic [31:0]        sgn;

	always_comb begin
		ua   = unpack32(a);
		ub   = unpack32(b);
		uc   = unpack32(c);
		np   = ua.neg ^ ub.neg;

		xs   = 7'd13 + {1'b0, lzp_q};
		ys   = 7'd37 + {2'b0, lzc_q};
		xm   = {16'b0, prod_q} << xs;
		ym   = {40'b0, mc_q} << ys;
		xe   = pe_q - $signed({5'b0, xs});
		ye   = ec_q - $signed({5'b0, ys});
		swap = (ye > xe) || ((ye == xe) && (ym > xm));

		dsh  = dexp_q[5:0];
		if (dexp_q >= 12'd63) begin
			yal = {63'b0, (small_m_q != 64'd0)};
		end else begin
			yal = (small_m_q >> dsh) |
				{63'b0, ((small_m_q & ((64'd1 << dsh) - 64'd1)) != 64'd0)};
		end
		tsum = (big_n_q == small_n_q) ? (big_m_q + yal) : (big_m_q - yal);

		pmsb = $signed({5'b0, 7'd63 - lzs_q});
		s1   = pmsb - $signed({7'b0, fb});
		s2   = lsbmin - sum_e_q;

		ext  = {sum_m_q, 64'b0} >> shift_q[5:0];
		nsh  = 5'(-shift_q);
		lsh  = sum_m_q << nsh;

		qr   = q_q + {24'b0, (g_q & (st_q | q_q[0]))};
		v    = ({28'b0, bexp_q} << fb) + {15'b0, qr};
		sgn  = sum_n_q ? sbit : 32'd0;
	end

	always_ff @(posedge clk) begin
		unique case (step)
			cbdq_pkg::STEP_UNPACK: begin
				rfmt_q  <= (op == cbdq_pkg::OP_NARROW) ? fmt : cbdq_pkg::FMT_FP32;
				prod_q  <= ua.m * ub.m;
				pe_q    <= ua.e + ub.e;
				pn_q    <= np;
				mc_q    <= uc.m;
				ec_q    <= uc.e;
				nc_q    <= uc.neg;
				czero_q <= (uc.cls == CLS_ZERO);
				if (op == cbdq_pkg::OP_NARROW) begin
					sum_m_q <= {40'b0, ua.m};
					sum_e_q <= ua.e;
					sum_n_q <= ua.neg;
					sp_q    <= 1'b1;
					if (fmt == cbdq_pkg::FMT_FP16 || fmt == cbdq_pkg::FMT_BF16) begin
						if (ua.cls == CLS_NAN) begin
							spv_q <= (fmt == cbdq_pkg::FMT_FP16) ? 32'h7E00 : 32'h7FC0;
						end else if (ua.cls == CLS_INF) begin
							spv_q <= {16'b0, ua.neg, 15'b0} |
								((fmt == cbdq_pkg::FMT_FP16) ? 32'h7C00 : 32'h7F80);
						end else if (ua.cls == CLS_ZERO) begin
							spv_q <= {16'b0, ua.neg, 15'b0};
						end else begin
							sp_q  <= 1'b0;
							spv_q <= '0;
						end
					end else begin
						spv_q <= a;
					end
				end else begin
					sp_q <= 1'b1;
					if (ua.cls == CLS_NAN || ub.cls == CLS_NAN || uc.cls == CLS_NAN) begin
						spv_q <= cbdq_pkg::NAN32;
					end else if (ua.cls == CLS_INF || ub.cls == CLS_INF) begin
						if (ua.cls == CLS_ZERO || ub.cls == CLS_ZERO) begin
							spv_q <= cbdq_pkg::NAN32;
						end else if (uc.cls == CLS_INF && uc.neg != np) begin
							spv_q <= cbdq_pkg::NAN32;
						end else begin
							spv_q <= {np, cbdq_pkg::INF32[30:0]};
						end
					end else if (uc.cls == CLS_INF) begin
						spv_q <= c;
					end else if (ua.cls == CLS_ZERO || ub.cls == CLS_ZERO) begin
						spv_q <= (uc.cls == CLS_ZERO) ? {np & uc.neg, 31'b0} : c;
					end else begin
						sp_q  <= 1'b0;
						spv_q <= '0;
					end
				end
			end
			cbdq_pkg::STEP_NORM: begin
				lzp_q <= lzc48(prod_q);
				lzc_q <= lzc24(mc_q);
			end
			cbdq_pkg::STEP_ALIGN: begin
				if (swap) begin
					big_m_q   <= ym;  big_e_q <= ye; big_n_q <= nc_q;
					small_m_q <= xm;  small_n_q <= pn_q;
					dexp_q    <= 12'(ye - xe);
				end else begin
					big_m_q   <= xm;  big_e_q <= xe; big_n_q <= pn_q;
					small_m_q <= ym;  small_n_q <= nc_q;
					dexp_q    <= 12'(xe - ye);
				end
			end
			cbdq_pkg::STEP_ADD: begin
				if (czero_q) begin
					sum_m_q <= {16'b0, prod_q};
					sum_e_q <= pe_q;
					sum_n_q <= pn_q;
				end else begin
					sum_m_q <= tsum;
					sum_e_q <= big_e_q;
					sum_n_q <= big_n_q;
					// exact cancellation gives +0
					if (tsum == 64'd0 && !sp_q) begin
						sp_q  <= 1'b1;
						spv_q <= '0;
					end
				end
			end
			cbdq_pkg::STEP_LZ: begin
				lzs_q <= lzc64(sum_m_q);
			end
			cbdq_pkg::STEP_SHC: begin
				shift_q <= (s1 > s2) ? s1 : s2;
				zero_q  <= ((s1 > s2) ? s1 : s2) > 12'sd63;
			end
			cbdq_pkg::STEP_SHF: begin
				bexp_q <= 12'(sum_e_q + shift_q - lsbmin);
				if (shift_q <= 12'sd0) begin
					q_q  <= lsh[24:0];
					g_q  <= 1'b0;
					st_q <= 1'b0;
				end else begin
					q_q  <= ext[88:64];
					g_q  <= ext[63];
					st_q <= (ext[62:0] != 63'd0);
				end
			end
			cbdq_pkg::STEP_PACK: begin
				if (sp_q) begin
					res_q <= spv_q;
				end else if (zero_q) begin
					res_q <= sgn;
				end else if (v >= {8'b0, infb}) begin
					res_q <= sgn | infb;
				end else begin
					res_q <= sgn | v[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cbdq_datapath.sv =====
`default_nettype none

module cbdq_datapath #(
	parameter int MAX_CODE_BITS = 6
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_wr_en,
	input  wire [cbdq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [cbdq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire                            action,
	input  wire [5:0]                      table_slot,
	input  wire [31:0]                     value_bits,
	input  wire [15:0]                     packed_window,
	input  wire [2:0]                      code_pos,
	input  wire                            last_element,
	input  wire [31:0]                     row_scale,
	input  wire [31:0]                     bias_value,
	input  wire cbdq_pkg::cmd_t            cmd,
	output cbdq_pkg::status_t              status,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [31:0]                    result_bits
);

	logic [1:0]  element_format_q;
	logic [2:0]  code_bits_q;
	logic        bias_enable_q;

	logic [31:0] cb_mem [cbdq_pkg::CB_DEPTH];
	logic [31:0] cbrd_q;
	logic [31:0] act_q, scale_q, bias_q, sum_q, r_q, out_q;
	logic        last_q;
	logic        out_valid_q;
	logic [31:0] opa, opb, opc, fpu_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_format_q <= cbdq_pkg::FMT_FP32;
			code_bits_q      <= 3'd4;
			bias_enable_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cbdq_pkg::REG_ELEMENT_FORMAT: element_format_q <= cfg_wdata[1:0];
				cbdq_pkg::REG_CODE_BITS:      code_bits_q      <= cfg_wdata;
				cbdq_pkg::REG_BIAS_ENABLE:    bias_enable_q    <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// code extraction
	logic [3:0]  cbits;
	logic [15:0] code_full;
	logic [5:0]  code_idx;

	always_comb begin
		if (code_bits_q == 3'd0) begin
			cbits = 4'd1;
		end else if (int'({1'b0, code_bits_q}) > MAX_CODE_BITS) begin
			cbits = 4'(MAX_CODE_BITS);
		end else begin
			cbits = {1'b0, code_bits_q};
		end
		code_full = (packed_window >> code_pos) & ((16'd1 << cbits) - 16'd1);
		code_idx  = code_full[5:0];
	end

	// activation widening
	logic [3:0]  hmsb;
	logic [31:0] act_w;
	logic [9:0]  hfr;
	logic [22:0] hfrac;

	always_comb begin
		hfr  = value_bits[9:0];
		hmsb = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (hfr[i]) hmsb = 4'(i);
		end
		hfrac = 23'({13'b0, hfr} << (5'd23 - {1'b0, hmsb}));
		unique case (element_format_q)
			cbdq_pkg::FMT_FP16: begin
				if (value_bits[14:10] == 5'h1F) begin
					act_w = (hfr != 10'd0) ? cbdq_pkg::NAN32 :
						{value_bits[15], cbdq_pkg::INF32[30:0]};
				end else if (value_bits[14:10] == 5'h00) begin
					if (hfr == 10'd0) begin
						act_w = {value_bits[15], 31'b0};
					end else begin
						act_w = {value_bits[15], 8'(hmsb) + 8'd103, hfrac};
					end
				end else begin
					act_w = {value_bits[15], 8'(value_bits[14:10]) + 8'd112, hfr, 13'b0};
				end
			end
			cbdq_pkg::FMT_BF16: act_w = {value_bits[15:0], 16'b0};
			default:            act_w = value_bits;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (action == cbdq_pkg::ACT_LOAD) begin
				cb_mem[table_slot] <= value_bits;
			end else begin
				cbrd_q <= cb_mem[code_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			act_q   <= act_w;
			scale_q <= row_scale;
			bias_q  <= bias_value;
		end
		if (cmd.r_wr) r_q <= fpu_res;
		if (cmd.out_load) out_q <= fpu_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) last_q <= last_element;
			if (cmd.sum_clr) begin
				sum_q <= '0;
			end else if (cmd.sum_wr) begin
				sum_q <= fpu_res;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		unique case (cmd.a_sel)
			cbdq_pkg::OPA_SUM: opa = sum_q;
			cbdq_pkg::OPA_RES: opa = r_q;
			default:           opa = act_q;
		endcase
		unique case (cmd.b_sel)
			cbdq_pkg::OPB_SCALE: opb = scale_q;
			cbdq_pkg::OPB_ONE:   opb = cbdq_pkg::ONE32;
			default:             opb = cbrd_q;
		endcase
		unique case (cmd.c_sel)
			cbdq_pkg::OPC_NEGZERO: opc = cbdq_pkg::NEGZERO32;
			cbdq_pkg::OPC_BIAS:    opc = bias_q;
			default:               opc = sum_q;
		endcase
	end

	cbdq_fpu u_fpu (
		.clk  (clk),
		.step (cmd.step),
		.op   (cmd.op),
		.fmt  (element_format_q),
		.a    (opa),
		.b    (opb),
		.c    (opc),
		.res  (fpu_res)
	);

	assign status.last     = last_q;
	assign status.bias_en  = bias_enable_q;
	assign status.out_full = out_valid_q;
	assign out_valid       = out_valid_q;
	assign result_bits     = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cbdq_ctrl.sv =====
`default_nettype none

module cbdq_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    item_valid,
	input  wire                    item_action,
	input  wire cbdq_pkg::status_t status,
	output logic                   item_ready,
	output cbdq_pkg::cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_UNPACK, ST_NORM, ST_ALIGN, ST_ADD,
		ST_LZ, ST_SHC, ST_SHF, ST_PACK, ST_WB
	} state_t;

	// which operation the shared unit is running
	typedef enum logic [1:0] {PH_ACC, PH_SCALE, PH_BIAS, PH_NARROW} phase_t;

	state_t state_q;
	phase_t phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_ACC;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid && item_action == cbdq_pkg::ACT_ELEMENT) begin
						state_q <= ST_UNPACK;
						phase_q <= PH_ACC;
					end
				end
				ST_UNPACK: state_q <= (phase_q == PH_NARROW) ? ST_LZ : ST_NORM;
				ST_NORM:   state_q <= ST_ALIGN;
				ST_ALIGN:  state_q <= ST_ADD;
				ST_ADD:    state_q <= ST_LZ;
				ST_LZ:     state_q <= ST_SHC;
				ST_SHC:    state_q <= ST_SHF;
				ST_SHF:    state_q <= ST_PACK;
				ST_PACK:   state_q <= ST_WB;
				ST_WB: begin
					unique case (phase_q)
						PH_ACC: begin
							state_q <= status.last ? ST_UNPACK : ST_IDLE;
							if (status.last) phase_q <= PH_SCALE;
						end
						PH_SCALE: begin
							state_q <= ST_UNPACK;
							phase_q <= status.bias_en ? PH_BIAS : PH_NARROW;
						end
						PH_BIAS: begin
							state_q <= ST_UNPACK;
							phase_q <= PH_NARROW;
						end
						default: begin
							// hold the result until the output register is free
							if (!status.out_full) begin
								state_q <= ST_IDLE;
								phase_q <= PH_ACC;
							end
						end
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		item_ready = (state_q == ST_IDLE);
		cmd.take   = (state_q == ST_IDLE) && item_valid;

		unique case (state_q)
			ST_UNPACK: cmd.step = cbdq_pkg::STEP_UNPACK;
			ST_NORM:   cmd.step = cbdq_pkg::STEP_NORM;
			ST_ALIGN:  cmd.step = cbdq_pkg::STEP_ALIGN;
			ST_ADD:    cmd.step = cbdq_pkg::STEP_ADD;
			ST_LZ:     cmd.step = cbdq_pkg::STEP_LZ;
			ST_SHC:    cmd.step = cbdq_pkg::STEP_SHC;
			ST_SHF:    cmd.step = cbdq_pkg::STEP_SHF;
			ST_PACK:   cmd.step = cbdq_pkg::STEP_PACK;
			default:   cmd.step = cbdq_pkg::STEP_IDLE;
		endcase

		cmd.op = (phase_q == PH_NARROW) ? cbdq_pkg::OP_NARROW : cbdq_pkg::OP_FMA;
		unique case (phase_q)
			PH_ACC: begin
				cmd.a_sel = cbdq_pkg::OPA_ACT;
				cmd.b_sel = cbdq_pkg::OPB_CB;
				cmd.c_sel = cbdq_pkg::OPC_SUM;
			end
			PH_SCALE: begin
				cmd.a_sel = cbdq_pkg::OPA_SUM;
				cmd.b_sel = cbdq_pkg::OPB_SCALE;
				cmd.c_sel = cbdq_pkg::OPC_NEGZERO;
			end
			PH_BIAS: begin
				cmd.a_sel = cbdq_pkg::OPA_RES;
				cmd.b_sel = cbdq_pkg::OPB_ONE;
				cmd.c_sel = cbdq_pkg::OPC_BIAS;
			end
			default: begin
				cmd.a_sel = cbdq_pkg::OPA_RES;
				cmd.b_sel = cbdq_pkg::OPB_ONE;
				cmd.c_sel = cbdq_pkg::OPC_NEGZERO;
			end
		endcase

		cmd.sum_wr   = (state_q == ST_WB) && (phase_q == PH_ACC);
		cmd.r_wr     = (state_q == ST_WB) && (phase_q == PH_SCALE || phase_q == PH_BIAS);
		cmd.out_load = (state_q == ST_WB) && (phase_q == PH_NARROW) && !status.out_full;
		cmd.sum_clr  = cmd.out_load;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/codebook_dequant_dot_product.sv =====
`default_nettype none

// Channel  Dir  Handshake      Carries
// item     in   valid/ready    action, slot, activation, window, offset, last, scale, bias
// result   out  valid/ready    result_bits (element format, half types in low 16 bits)
// cfg      in   cfg_wr_en      element_format, code_bits, bias_enable
//
// A load request writes the codebook when taken. An element request reads the
// codebook when taken, then makes one pass through the shared fp32 multiply-add unit.
// A last element adds a pass for the scale, one more with bias, and a pass for rounding
// to the element format that skips the normalize, align and add steps.
// Reset is asynchronous and clears the sum and control; the codebook is not cleared.
// A finished result waits in the output register; a new request is taken meanwhile.
module codebook_dequant_dot_product #(
	parameter int MAX_CODE_BITS = 6
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_wr_en,
	input  wire [cbdq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [cbdq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	cbdq_item_if.sink                      item,
	cbdq_result_if.source                  result
);

	cbdq_pkg::cmd_t    cmd;
	cbdq_pkg::status_t status;
	logic              item_ready;
	logic              out_valid;
	logic [31:0]       out_bits;

	cbdq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_action (item.action),
		.status      (status),
		.item_ready  (item_ready),
		.cmd         (cmd)
	);

	cbdq_datapath #(
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.action        (item.action),
		.table_slot    (item.table_slot),
		.value_bits    (item.value_bits),
		.packed_window (item.packed_window),
		.code_pos      (item.code_pos),
		.last_element  (item.last_element),
		.row_scale     (item.row_scale),
		.bias_value    (item.bias_value),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_ready     (result.ready),
		.result_bits   (out_bits)
	);

	assign item.ready         = item_ready;
	assign result.valid       = out_valid;
	assign result.result_bits = out_bits;

endmodule

`default_nettype wire

// ===== dv/tb_codebook_dequant_dot_product.sv =====
`timescale 1ns / 100ps

module tb_codebook_dequant_dot_product;

	localparam int unsigned CFG_IDX_W  = cbdq_pkg::CFG_IDX_W;
	localparam int unsigned CFG_DATA_W = cbdq_pkg::CFG_DATA_W;
	localparam int unsigned CB_DEPTH   = cbdq_pkg::CB_DEPTH;

	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_FORMAT = cbdq_pkg::REG_ELEMENT_FORMAT;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS      = cbdq_pkg::REG_CODE_BITS;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE    = cbdq_pkg::REG_BIAS_ENABLE;

	localparam logic [1:0] FMT_FP32 = cbdq_pkg::FMT_FP32;
	localparam logic [1:0] FMT_FP16 = cbdq_pkg::FMT_FP16;
	localparam logic [1:0] FMT_BF16 = cbdq_pkg::FMT_BF16;

	localparam logic ACT_LOAD    = cbdq_pkg::ACT_LOAD;
	localparam logic ACT_ELEMENT = cbdq_pkg::ACT_ELEMENT;

	localparam logic [31:0] NAN32     = cbdq_pkg::NAN32;
	localparam logic [31:0] INF32     = cbdq_pkg::INF32;
	localparam logic [31:0] ONE32     = cbdq_pkg::ONE32;
	localparam logic [31:0] NEGZERO32 = cbdq_pkg::NEGZERO32;

	typedef struct packed {
		logic        action;
		logic [5:0]  slot;
		logic [31:0] value;
		logic [15:0] window;
		logic [2:0]  offset;
		logic        last;
		logic [31:0] scale;
		logic [31:0] bias;
	} req_t;

	typedef struct packed {
		req_t        req;
		logic        known;
		logic [31:0] dot;
	} dir_row_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 50;
	localparam int HOLD_CYCLES    = 400;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 75;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cbdq_item_if   item_ch ();
	cbdq_result_if res_ch ();

	codebook_dequant_dot_product u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (res_ch)
	);

	// predictor state
	logic [31:0] centroid [CB_DEPTH];
	logic [31:0] dot_acc;
	logic [1:0]  fmt;
	logic [2:0]  cbits;
	logic        bias_on;

	logic [31:0] pending_dots [$];
	int errors;
	int n_reqs;
	int n_dots;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	int hold_left;
	int quiet_cycles;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int msb64(longint unsigned v);
		int p;
		p = 0;
		while (v > 1) begin
			v = v >> 1;
			p++;
		end
		return p;
	endfunction

	function automatic logic [31:0] round_pack(bit neg, longint unsigned m, int e, int fb,
			int lsbmin, logic [31:0] infb, logic [31:0] signb);
		int sh;
		longint unsigned q, rem, half;
		longint v;
		logic [31:0] s;
		s = neg ? signb : 32'd0;
		sh = msb64(m) - fb;
		if (lsbmin - e > sh)
			sh = lsbmin - e;
		if (sh > 63)
			return s;
		if (sh <= 0) begin
			q = m << (-sh);
		end else begin
			rem = m & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			q = m >> sh;
			if (rem > half || (rem == half && q[0]))
				q++;
		end
		v = longint'(e + sh - lsbmin) * (longint'(1) << fb) + longint'(q);
		if (v >= longint'(infb))
			return s | infb;
		return s | v[31:0];
	endfunction

	// 0 zero, 1 finite, 2 infinity, 3 NaN
	function automatic int classify(logic [31:0] x, output bit neg,
			output longint unsigned m, output int e);
		neg = x[31];
		m = 0;
		e = 0;
		if (x[30:23] == 8'hFF)
			return (x[22:0] != 0) ? 3 : 2;
		if (x[30:23] == 8'h00) begin
			if (x[22:0] == 0)
				return 0;
			m = x[22:0];
			e = -149;
			return 1;
		end
		m = {1'b1, x[22:0]};
		e = int'(x[30:23]) - 150;
		return 1;
	endfunction

	function automatic logic [31:0] fused_mac(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		bit na, nb, nc, np, xn, yn, tn;
		longint unsigned ma, mb, mc, x, y, t;
		int ea, eb, ec, xe, ye, te, d, ka, kb, kc;
		ka = classify(a, na, ma, ea);
		kb = classify(b, nb, mb, eb);
		kc = classify(c, nc, mc, ec);
		if (ka == 3 || kb == 3 || kc == 3)
			return NAN32;
		np = na ^ nb;
		if (ka == 2 || kb == 2) begin
			if (ka == 0 || kb == 0)
				return NAN32;
			if (kc == 2 && nc != np)
				return NAN32;
			return {np, 31'd0} | INF32;
		end
		if (kc == 2)
			return c;
		if (ka == 0 || kb == 0) begin
			if (kc == 0)
				return (np && nc) ? NEGZERO32 : 32'd0;
			return c;
		end
		x = ma * mb;
		xe = ea + eb;
		if (kc == 0)
			return round_pack(np, x, xe, 23, -149, INF32, NEGZERO32);
		d = 60 - msb64(x);
		x = x << d;
		xe -= d;
		xn = np;
		d = 60 - msb64(mc);
		y = mc << d;
		ye = ec - d;
		yn = nc;
		if (ye > xe || (ye == xe && y > x)) begin
			t = x; x = y; y = t;
			te = xe; xe = ye; ye = te;
			tn = xn; xn = yn; yn = tn;
		end
		d = xe - ye;
		if (d >= 63)
			y = (y != 0) ? 64'd1 : 64'd0;
		else if (d > 0)
			y = (y >> d) | (((y & ((64'd1 << d) - 64'd1)) != 0) ? 64'd1 : 64'd0);
		if (xn == yn)
			x = x + y;
		else
			x = x - y;
		if (x == 0)
			return 32'd0;
		return round_pack(xn, x, xe, 23, -149, INF32, NEGZERO32);
	endfunction

	function automatic logic [31:0] widen_act(logic [31:0] v);
		logic [31:0] s;
		if (fmt == FMT_FP16) begin
			s = {v[15], 31'd0};
			if (v[14:10] == 5'h1F)
				return (v[9:0] != 0) ? NAN32 : (s | INF32);
			if (v[14:10] == 5'd0) begin
				if (v[9:0] == 0)
					return s;
				return round_pack(v[15], v[9:0], -24, 23, -149, INF32, NEGZERO32);
			end
			return s | ((32'(v[14:10]) + 32'd112) << 23) | (32'(v[9:0]) << 13);
		end
		if (fmt == FMT_BF16)
			return {v[15:0], 16'd0};
		return v;
	endfunction

	function automatic logic [31:0] narrow_dot(logic [31:0] v);
		bit neg;
		longint unsigned m;
		int e, k;
		if (fmt != FMT_FP16 && fmt != FMT_BF16)
			return v;
		k = classify(v, neg, m, e);
		if (fmt == FMT_FP16) begin
			if (k == 3) return 32'h7E00;
			if (k == 2) return {16'd0, neg, 15'h7C00};
			if (k == 0) return {16'd0, neg, 15'd0};
			return round_pack(neg, m, e, 10, -24, 32'h7C00, 32'h8000);
		end
		if (k == 3) return 32'h7FC0;
		if (k == 2) return {16'd0, neg, 15'h7F80};
		if (k == 0) return {16'd0, neg, 15'd0};
		return round_pack(neg, m, e, 7, -133, 32'h7F80, 32'h8000);
	endfunction

	// returns 1 when the request finishes a dot product
	function automatic bit predict_dot(req_t r, output logic [31:0] dot);
		int cb;
		logic [15:0] shifted;
		logic [5:0] code;
		logic [31:0] y;
		dot = 32'd0;
		if (r.action == ACT_LOAD) begin
			centroid[r.slot] = r.value;
			return 0;
		end
		cb = (cbits < 1) ? 1 : ((cbits > 6) ? 6 : int'(cbits));
		shifted = r.window >> r.offset;
		code = shifted[5:0] & 6'((1 << cb) - 1);
		dot_acc = fused_mac(widen_act(r.value), centroid[code], dot_acc);
		if (!r.last)
			return 0;
		y = fused_mac(dot_acc, r.scale, NEGZERO32);
		if (bias_on)
			y = fused_mac(y, ONE32, r.bias);
		dot_acc = 32'd0;
		dot = narrow_dot(y);
		return 1;
	endfunction

	function automatic logic [31:0] moderate_fp32();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return $urandom;
		if (pick < 11)
			return {1'($urandom), 31'd0};
		return {1'($urandom), 8'($urandom_range(115, 139)), 23'($urandom)};
	endfunction

	function automatic logic [31:0] random_act();
		if ($urandom_range(0, 99) < 8)
			return $urandom;
		if (fmt == FMT_FP16)
			return {16'($urandom), 1'($urandom), 5'($urandom_range(11, 19)), 10'($urandom)};
		if (fmt == FMT_BF16)
			return {16'($urandom), 1'($urandom), 8'($urandom_range(119, 135)), 7'($urandom)};
		return moderate_fp32();
	endfunction

	function automatic req_t random_req();
		req_t r;
		r.action = ($urandom_range(0, 99) < 15) ? ACT_LOAD : ACT_ELEMENT;
		r.slot = 6'($urandom);
		r.value = (r.action == ACT_LOAD) ? moderate_fp32() : random_act();
		r.window = 16'($urandom);
		r.offset = 3'($urandom);
		r.last = ($urandom_range(0, 3) == 0);
		r.scale = moderate_fp32();
		r.bias = moderate_fp32();
		return r;
	endfunction

	// the caller drops the write enable after its last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_ELEMENT_FORMAT: fmt = data[1:0];
			REG_CODE_BITS:      cbits = data;
			REG_BIAS_ENABLE:    bias_on = data[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_dots.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// drives one request and updates the predictor when it is taken
	task automatic send_req(req_t r, bit known, logic [31:0] typed);
		logic [31:0] dot;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.action        <= r.action;
		item_ch.table_slot    <= r.slot;
		item_ch.value_bits    <= r.value;
		item_ch.packed_window <= r.window;
		item_ch.code_pos      <= r.offset;
		item_ch.last_element  <= r.last;
		item_ch.row_scale     <= r.scale;
		item_ch.bias_value    <= r.bias;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		n_reqs++;
		if (predict_dot(r, dot))
			pending_dots.push_back(known ? typed : dot);
	endtask

	// result side: checking, stalls, long hold-off and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d results outstanding", $time,
					pending_dots.size());
				$display("Test completed with failures");
				$finish;
			end
		end
		if (res_ch.valid && res_ch.ready) begin
			n_dots++;
			if (pending_dots.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time,
					res_ch.result_bits);
				errors++;
			end else begin
				if (res_ch.result_bits !== pending_dots[0]) begin
					$display("%0t: result_bits mismatch, expected %h, actual %h", $time,
						pending_dots[0], res_ch.result_bits);
					errors++;
				end
				void'(pending_dots.pop_front());
			end
		end
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		dir_row_t dir_tab [12];
		logic [CFG_DATA_W-1:0] phase_cfg [NUM_PHASES][3];
		req_t r;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_LOAD;
		item_ch.table_slot = '0;
		item_ch.value_bits = '0;
		item_ch.packed_window = '0;
		item_ch.code_pos = '0;
		item_ch.last_element = 1'b0;
		item_ch.row_scale = '0;
		item_ch.bias_value = '0;
		res_ch.ready = 1'b0;
		errors = 0;
		n_reqs = 0;
		n_dots = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		dot_acc = 32'd0;
		fmt = FMT_FP32;
		cbits = 3'd4;
		bias_on = 1'b0;

		// format, code width, bias; includes unused format and out-of-range widths
		phase_cfg = '{
			'{3'(FMT_FP32), 3'd4, 3'd0}, '{3'(FMT_FP16), 3'd6, 3'd1},
			'{3'(FMT_BF16), 3'd1, 3'd0}, '{3'd3, 3'd0, 3'd1},
			'{3'(FMT_FP16), 3'd7, 3'd0}, '{3'(FMT_BF16), 3'd5, 3'd1},
			'{3'(FMT_FP32), 3'd6, 3'd1}, '{3'(FMT_FP16), 3'd2, 3'd0}};

		// codebook entries 0..2 hold 1.0, +inf and the largest finite value
		dir_tab = '{
			'{'{ACT_ELEMENT, 6'd0, 32'h4000_0000, 16'h0000, 3'd0, 1'b1, ONE32, 32'd0},
				1'b1, 32'h4000_0000},
			'{'{ACT_ELEMENT, 6'd0, 32'hFFFF_FFFF, 16'h0000, 3'd0, 1'b1, ONE32, 32'd0},
				1'b1, NAN32},
			// zero times infinity
			'{'{ACT_ELEMENT, 6'd0, 32'h0000_0000, 16'h0001, 3'd0, 1'b1, ONE32, 32'd0},
				1'b1, NAN32},
			'{'{ACT_ELEMENT, 6'd0, ONE32, 16'h0001, 3'd0, 1'b1, ONE32, 32'd0},
				1'b1, INF32},
			// overflow on rounding
			'{'{ACT_ELEMENT, 6'd0, 32'h7F7F_FFFF, 16'h0002, 3'd0, 1'b1, ONE32, 32'd0},
				1'b1, INF32},
			'{'{ACT_ELEMENT, 6'd0, NEGZERO32, 16'h0000, 3'd0, 1'b1, ONE32, 32'd0},
				1'b1, 32'd0},
			// smallest subnormal survives
			'{'{ACT_ELEMENT, 6'd0, 32'h0000_0001, 16'h0000, 3'd0, 1'b1, ONE32, 32'd0},
				1'b1, 32'h0000_0001},
			'{'{ACT_LOAD, 6'd63, 32'h0000_0000, 16'hFFFF, 3'd7, 1'b1, 32'hFFFF_FFFF,
				32'hFFFF_FFFF}, 1'b0, 32'd0},
			'{'{ACT_ELEMENT, 6'd0, ONE32, 16'h0000, 3'd0, 1'b0, ONE32, 32'd0}, 1'b0, 32'd0},
			'{'{ACT_ELEMENT, 6'd0, ONE32, 16'hFFFF, 3'd7, 1'b1, 32'h3F00_0000, 32'd0},
				1'b0, 32'd0},
			'{'{ACT_ELEMENT, 6'd0, ONE32, 16'h0000, 3'd0, 1'b1, 32'h0000_0000, 32'd0},
				1'b0, 32'd0},
			// infinite sum scaled by zero
			'{'{ACT_ELEMENT, 6'd0, INF32, 16'h0000, 3'd0, 1'b1, 32'h0000_0000, 32'd0},
				1'b1, NAN32}};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole codebook so no entry is read before it is written
		for (int s = 0; s < CB_DEPTH; s++) begin
			r = random_req();
			r.action = ACT_LOAD;
			r.slot = 6'(s);
			r.value = (s == 0) ? ONE32 : (s == 1) ? INF32 : (s == 2) ? 32'h7F7F_FFFF :
				moderate_fp32();
			send_req(r, 1'b0, 32'd0);
		end
		foreach (dir_tab[i])
			send_req(dir_tab[i].req, dir_tab[i].known, dir_tab[i].dot);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
			wait_drained();
			write_reg(REG_ELEMENT_FORMAT, phase_cfg[ph][0]);
			write_reg(REG_CODE_BITS, phase_cfg[ph][1]);
			write_reg(REG_BIAS_ENABLE, phase_cfg[ph][2]);
			cfg_wr_en <= 1'b0;
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// receiver blocks while requests keep coming, to back up the input
				if (ph == 4 && k == 10)
					hold_req = 1'b1;
				if (ph == 6 && k == 30) begin
					item_ch.valid <= 1'b0;
					@(posedge clk);
					while (pending_dots.size() != 0)
						@(posedge clk);
				end
				r = random_req();
				if (ph == 4 && k >= 10 && k < 30)
					r.last = 1'b1;
				send_req(r, 1'b0, 32'd0);
			end
		end
		item_ch.valid <= 1'b0;
		@(posedge clk);
		wait_drained();

		$display("Covered %0d requests and %0d dot products over %0d register settings,",
			n_reqs, n_dots, NUM_PHASES + 1);
		$display("with input gaps, output stalls and a long output hold-off.");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== codebook_dequant_dot_product.f =====
hw/rtl/cbdq_pkg.sv
hw/rtl/cbdq_if.sv
hw/rtl/cbdq_fpu.sv
hw/rtl/cbdq_datapath.sv
hw/rtl/cbdq_ctrl.sv
hw/rtl/codebook_dequant_dot_product.sv
dv/tb_codebook_dequant_dot_product.sv
